[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers with a common clock edge and report, with and without a reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nfa_bitset_matcher: assertion failed");

// check only outside of reset (reset is active low)
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nfa_bitset_matcher: assertion failed");

`endif

[design/nfa_bm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_bm_pkg
// Shared types, codes and defaults of the NFA bitset matcher.
// ----------------------------------------------------------------------------
package nfa_bm_pkg;

    localparam int NUM_STATES_DEF  = 32;
    localparam int NUM_SYMBOLS_DEF = 128;

    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 7;
    localparam int STATE_W  = 5;
    localparam int SET_W    = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESTART = 2'd0,
        ACT_CONSUME = 2'd1,
        ACT_ADD     = 2'd2,
        ACT_ADD_ALL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  src_state;
        logic [STATE_W-1:0]  dst_state;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

endpackage

[design/nfa_bm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_bm_core
// Transition table memory with its clearing pass, scan and read-modify-write
// sequencer, and the active state set.
// ----------------------------------------------------------------------------
module nfa_bm_core #(
    parameter int NUM_STATES  = nfa_bm_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfa_bm_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  nfa_bm_pkg::t_item           i_item,
    input  logic                        i_out_free,
    output nfa_bm_pkg::t_core_status    o_status,
    output logic [nfa_bm_pkg::SET_W-1:0] o_active_set
);

    localparam int ST_W   = $clog2(NUM_STATES);
    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W = ST_W + SYM_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [NUM_STATES-1:0] mem [DEPTH];

    nfa_bm_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]     r_clr;
    logic [SYM_W:0]        r_sym;
    logic [SYM_W:0]        r_sym_end;
    logic [ST_W-1:0]       r_src;
    logic [NUM_STATES-1:0] r_dst_bit;
    logic [ST_W:0]         r_cnt;
    logic                  r_gate;
    logic [NUM_STATES-1:0] r_acc;
    logic [NUM_STATES-1:0] r_active;
    logic                  r_wr_pend;
    logic [ADDR_W-1:0]     r_wr_addr;
    logic [NUM_STATES-1:0] r_rdata;

    logic                  sym_ok, src_ok, dst_ok;
    logic [SYM_W-1:0]      sym_idx;
    logic [ST_W-1:0]       src_idx, dst_idx;
    logic                  scan_end, add_end;
    logic [NUM_STATES-1:0] gated;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [NUM_STATES-1:0] mem_wdata;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;

    assign sym_ok   = int'(i_item.symbol) < NUM_SYMBOLS;
    assign src_ok   = int'(i_item.src_state) < NUM_STATES;
    assign dst_ok   = int'(i_item.dst_state) < NUM_STATES;
    assign sym_idx  = SYM_W'(i_item.symbol);
    assign src_idx  = ST_W'(i_item.src_state);
    assign dst_idx  = ST_W'(i_item.dst_state);
    assign scan_end = r_cnt == (ST_W+1)'(NUM_STATES);
    assign add_end  = r_sym == r_sym_end;
    assign gated    = r_gate ? r_rdata : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nfa_bm_pkg::ST_CLEAR: begin
                if (&r_clr) n_state = nfa_bm_pkg::ST_IDLE;
            end
            nfa_bm_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_item.action)
                        nfa_bm_pkg::ACT_CONSUME: begin
                            n_state = sym_ok ? nfa_bm_pkg::ST_SCAN : nfa_bm_pkg::ST_RESULT;
                        end
                        nfa_bm_pkg::ACT_ADD: begin
                            n_state = (sym_ok && src_ok && dst_ok) ? nfa_bm_pkg::ST_ADD
                                                                   : nfa_bm_pkg::ST_RESULT;
                        end
                        nfa_bm_pkg::ACT_ADD_ALL: begin
                            n_state = (src_ok && dst_ok) ? nfa_bm_pkg::ST_ADD
                                                         : nfa_bm_pkg::ST_RESULT;
                        end
                        default: begin
                            n_state = nfa_bm_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            nfa_bm_pkg::ST_SCAN: begin
                if (scan_end) n_state = nfa_bm_pkg::ST_RESULT;
            end
            nfa_bm_pkg::ST_ADD: begin
                if (add_end) n_state = nfa_bm_pkg::ST_RESULT;
            end
            nfa_bm_pkg::ST_RESULT: begin
                if (i_out_free) n_state = nfa_bm_pkg::ST_IDLE;
            end
            default: begin
                n_state = nfa_bm_pkg::ST_CLEAR;
            end
        endcase
    end

    // memory control and status
    always_comb begin
        mem_we        = 1'b0;
        mem_waddr     = r_wr_addr;
        mem_wdata     = r_rdata | r_dst_bit;
        rd_en         = 1'b0;
        rd_addr       = {r_src, r_sym[SYM_W-1:0]};
        o_status.busy = r_state != nfa_bm_pkg::ST_IDLE;
        o_status.done = 1'b0;
        case (r_state)
            nfa_bm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            nfa_bm_pkg::ST_SCAN: begin
                rd_en   = !scan_end;
                rd_addr = {r_cnt[ST_W-1:0], r_sym[SYM_W-1:0]};
            end
            nfa_bm_pkg::ST_ADD: begin
                rd_en  = !add_end;
                mem_we = r_wr_pend;
            end
            nfa_bm_pkg::ST_RESULT: begin
                o_status.done = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfa_bm_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_active  <= NUM_STATES'(1);
            r_wr_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                nfa_bm_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                end
                nfa_bm_pkg::ST_IDLE: begin
                    r_wr_pend <= 1'b0;
                    if (i_start) begin
                        r_src     <= src_idx;
                        r_dst_bit <= NUM_STATES'(1) << dst_idx;
                        r_cnt     <= '0;
                        r_acc     <= '0;
                        r_gate    <= 1'b0;
                        if (i_item.action == nfa_bm_pkg::ACT_ADD_ALL) begin
                            r_sym     <= '0;
                            r_sym_end <= (SYM_W+1)'(NUM_SYMBOLS);
                        end else begin
                            r_sym     <= {1'b0, sym_idx};
                            r_sym_end <= {1'b0, sym_idx} + (SYM_W+1)'(1);
                        end
                        if (i_item.action == nfa_bm_pkg::ACT_RESTART) begin
                            r_active <= NUM_STATES'(1);
                        end
                        if (i_item.action == nfa_bm_pkg::ACT_CONSUME && !sym_ok) begin
                            r_active <= '0;
                        end
                    end
                end
                nfa_bm_pkg::ST_SCAN: begin
                    if (scan_end) begin
                        r_active <= r_acc | gated;
                    end else begin
                        r_cnt  <= r_cnt + (ST_W+1)'(1);
                        r_gate <= r_active[r_cnt[ST_W-1:0]];
                        r_acc  <= r_acc | gated;
                    end
                end
                nfa_bm_pkg::ST_ADD: begin
                    if (rd_en) begin
                        r_sym     <= r_sym + (SYM_W+1)'(1);
                        r_wr_addr <= rd_addr;
                        r_wr_pend <= 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_active_set = nfa_bm_pkg::SET_W'(r_active);

endmodule

[design/nfa_bitset_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_bitset_matcher
// NFA simulation over an active state bitset and a transition table memory.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  action, symbol, src_state, dst_state
//   out      output     o_out_valid/i_out_stall accepted, active_states
//   cfg      input      i_cfg_valid/o_cfg_ready accept_mask
//
// Consume: one table read per state on the memory read port.
// Single add: one RMW; add on all symbols: one RMW per symbol.
// Restart and ignored adds go straight to the result.
// After reset the table is cleared one entry a cycle, 4096 entries by default
// (NUM_STATES x NUM_SYMBOLS rounded up to powers of two); input is stalled then.
// A finished word waits in the output register while the next input is taken.
// ----------------------------------------------------------------------------
module nfa_bitset_matcher #(
    parameter int NUM_STATES  = nfa_bm_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfa_bm_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [nfa_bm_pkg::ACTION_W-1:0]   i_action,
    input  logic [nfa_bm_pkg::SYMBOL_W-1:0]   i_symbol,
    input  logic [nfa_bm_pkg::STATE_W-1:0]    i_src_state,
    input  logic [nfa_bm_pkg::STATE_W-1:0]    i_dst_state,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    output logic [nfa_bm_pkg::SET_W-1:0]      o_active_states,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nfa_bm_pkg::SET_W-1:0]      i_cfg_data
);

    nfa_bm_pkg::t_item        item;
    nfa_bm_pkg::t_core_status status;
    logic [nfa_bm_pkg::SET_W-1:0] core_set;
    logic                     in_acc;
    logic                     out_free;

    logic [nfa_bm_pkg::SET_W-1:0] r_accept_mask;
    logic                         r_out_valid;
    logic                         r_accepted;
    logic [nfa_bm_pkg::SET_W-1:0] r_active_out;

    assign item.action    = nfa_bm_pkg::t_action'(i_action);
    assign item.symbol    = i_symbol;
    assign item.src_state = i_src_state;
    assign item.dst_state = i_dst_state;

    assign o_in_stall = status.busy;
    assign in_acc     = i_in_valid && !status.busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    nfa_bm_core #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc),
        .i_item       (item),
        .i_out_free   (out_free),
        .o_status     (status),
        .o_active_set (core_set)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_mask <= '0;
        end else if (i_cfg_valid) begin
            r_accept_mask <= i_cfg_data;
        end
    end

    // output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_active_out <= core_set;
            r_accepted   <= |(core_set & r_accept_mask);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_active_states = r_active_out;

endmodule

[design/nfa_bm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_bm_checker
// Port-level checks of the NFA bitset matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_bm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [nfa_bm_pkg::ACTION_W-1:0] i_action,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_accepted,
    input logic [nfa_bm_pkg::SET_W-1:0]    o_active_states
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    `ASSERT_RST(a_stall_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_active_states)
            && $stable(o_accepted))

    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> o_in_stall)

    `ASSERT_RST(a_word_from_busy, i_clk, i_rst_n,
        o_out_valid && (!$past(o_out_valid) || !$past(i_out_stall)) |-> $past(o_in_stall))

    `ASSERT_RST(a_restart_set, i_clk, i_rst_n,
        in_acc && i_action == nfa_bm_pkg::ACT_RESTART && !o_out_valid
            |=> ##1 o_out_valid && o_active_states == nfa_bm_pkg::SET_W'(1))

endmodule

bind nfa_bitset_matcher nfa_bm_checker u_nfa_bm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_action        (i_action),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_accepted      (o_accepted),
    .o_active_states (o_active_states)
);
